// ----- hw/rtl/swp_pkg.sv -----
// package for the scan window polar to xy block: widths, constants, codes and types
package swp_pkg;

  localparam int unsigned RANGE_W = 16;
  localparam int unsigned IDX_W   = 11;
  localparam int unsigned ANG_W   = 16;
  localparam int unsigned LEN_W   = 12;
  localparam int unsigned XY_W    = 17;
  localparam int unsigned CIDX_W  = 2;
  localparam int unsigned CDATA_W = 16;

  localparam int unsigned MAG_W  = 14;
  localparam int unsigned PI_W   = 32;
  localparam int unsigned TH_W   = 30;
  localparam int unsigned X2_W   = 30;
  localparam int unsigned S_W    = 31;
  localparam int unsigned RCP_W  = 32;
  localparam int unsigned Q_FRAC = 30;

  localparam logic [S_W-1:0]   Q30_ONE     = S_W'(64'd1 << Q_FRAC);
  localparam logic [PI_W-1:0]  PI_Q30      = 32'd3373259426;
  localparam logic [ANG_W-1:0] EIGHTH_TURN = 16'd8192;
  localparam logic [MAG_W-1:0] MAG_EIGHTH  = 14'd8192;
  localparam logic [47:0]      ROUND_HALF  = 48'd1 << (Q_FRAC - 1);

  localparam int unsigned N_COS    = 5;
  localparam int unsigned N_SIN    = 4;
  localparam int unsigned STEP_LAT = 3;
  localparam int unsigned COS_DIV [N_COS] = '{90, 56, 30, 12, 2};
  localparam int unsigned SIN_DIV [N_SIN] = '{72, 42, 20, 6};

  localparam logic [LEN_W-1:0] SCAN_LEN_MID  = 12'd720;
  localparam logic [LEN_W-1:0] SCAN_LEN_LONG = 12'd1080;
  localparam logic [IDX_W-1:0] RIGHT_MID     = 11'd180;
  localparam logic [IDX_W-1:0] LEFT_MID      = 11'd540;
  localparam logic [IDX_W-1:0] RIGHT_LONG    = 11'd270;
  localparam logic [IDX_W-1:0] LEFT_LONG     = 11'd810;
  localparam logic [IDX_W-1:0] RIGHT_DEF     = 11'd90;
  localparam logic [IDX_W-1:0] LEFT_DEF      = 11'd270;

  localparam logic [LEN_W-1:0] RST_SCAN_LEN  = 12'd360;
  localparam logic [ANG_W-1:0] RST_START_ANG = 16'h8000;
  localparam logic [ANG_W-1:0] RST_ANG_STEP  = 16'd182;

  typedef enum logic [CIDX_W-1:0] {
    CFG_SCAN_LENGTH = 2'd0,
    CFG_START_ANGLE = 2'd1,
    CFG_ANGLE_STEP  = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_e;

  typedef struct packed {
    logic [RANGE_W-1:0] range;
    logic [IDX_W-1:0]   idx;
    logic               inwin;
    quad_e              quad;
    logic               neg;
    logic [TH_W-1:0]    th;
    logic [X2_W-1:0]    x2;
  } swp_side_t;

endpackage

// ----- hw/rtl/swp_horner_step.sv -----
// one horner step of the series: s_o = 1 - ((x2 * s) >> 30) / DIV, three register stages
module swp_horner_step
  import swp_pkg::*;
#(
  parameter int unsigned DIV = 2
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [X2_W-1:0] x2_i,
  input  logic [S_W-1:0]  s_i,
  output logic [S_W-1:0]  s_o
);

  localparam int unsigned PROD_W = X2_W + S_W;
  localparam int unsigned MP_W   = X2_W + RCP_W;
  localparam int unsigned SH     = Q_FRAC + $clog2(DIV);
  localparam logic [63:0] RECIP_WIDE = ((64'd1 << SH) + 64'(DIV) - 64'd1) / 64'(DIV);
  localparam logic [RCP_W-1:0] RECIP = RECIP_WIDE[RCP_W-1:0];

  logic [PROD_W-1:0] prod_d, prod_q;
  logic [MP_W-1:0]   mp_d, mp_q;
  logic [X2_W-1:0]   scaled;
  logic [S_W-1:0]    s_d, s_q;

  assign prod_d = {{S_W{1'b0}}, x2_i} * {{X2_W{1'b0}}, s_i};
  assign scaled = prod_q[Q_FRAC+X2_W-1:Q_FRAC];
  assign mp_d   = {{RCP_W{1'b0}}, scaled} * {{X2_W{1'b0}}, RECIP};
  assign s_d    = Q30_ONE - S_W'(mp_q >> SH);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      mp_q   <= mp_d;
      s_q    <= s_d;
    end
  end

  assign s_o = s_q;

endmodule

// ----- hw/rtl/scan_window_polar_to_xy.sv -----
// top level: lidar sample polar to xy conversion with forward window flag
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-------------------------------------
//  in      | in        | in_valid_i / in_ready_o    | range_mm_i, sample_index_i
//  out     | out       | out_valid_o / out_ready_i  | x_mm_o, y_mm_o, in_window_o, index_echo_o
//  cfg     | in        | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
//  one word per cycle while the output is not stalled; each word passes through the
//  five three-stage horner steps of the cosine series plus angle and output multipliers
//  reset clears the valid bits and loads the register defaults, no clearing pass
//  a stall on the output freezes every stage at once; a word only moves forward
//  the cfg port always takes a write, unknown indexes are dropped
module scan_window_polar_to_xy
  import swp_pkg::*;
#(
  parameter int unsigned MAX_SAMPLES = 2048
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [RANGE_W-1:0]       range_mm_i,
  input  logic [IDX_W-1:0]         sample_index_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [XY_W-1:0]   x_mm_o,
  output logic signed [XY_W-1:0]   y_mm_o,
  output logic                     in_window_o,
  output logic [IDX_W-1:0]         index_echo_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CIDX_W-1:0]        cfg_index_i,
  input  logic [CDATA_W-1:0]       cfg_data_i
);

  localparam int unsigned MS_W   = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned CMP_W  = (MS_W > LEN_W) ? MS_W : LEN_W;
  localparam int unsigned ST_X2  = 3;
  localparam int unsigned ST_SIN = 2 + STEP_LAT * N_SIN;
  localparam int unsigned ST_COS = 2 + STEP_LAT * N_COS;
  localparam int unsigned ST_MUL = ST_COS + 1;
  localparam int unsigned NSTG   = ST_MUL + 2;
  localparam int unsigned SB_LAST = ST_MUL;

  logic [LEN_W-1:0] scan_len_q;
  logic [ANG_W-1:0] start_ang_q;
  logic [ANG_W-1:0] ang_step_q;

  logic            en;
  logic [NSTG-1:0] vld_q;

  swp_side_t sb_q [SB_LAST+1];
  swp_side_t sb_d [SB_LAST+1];

  // config registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_len_q  <= RST_SCAN_LEN;
      start_ang_q <= RST_START_ANG;
      ang_step_q  <= RST_ANG_STEP;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_SCAN_LENGTH: scan_len_q  <= cfg_data_i[LEN_W-1:0];
        CFG_START_ANGLE: start_ang_q <= cfg_data_i[ANG_W-1:0];
        CFG_ANGLE_STEP:  ang_step_q  <= cfg_data_i[ANG_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  assign en         = !vld_q[NSTG-1] || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTG-2:0], in_valid_i};
    end
  end

  // stage 0: angle and window
  logic [ANG_W-1:0] idx_step;
  logic [ANG_W-1:0] ang_d, ang_q;
  logic [IDX_W-1:0] right_edge, left_edge;
  logic [CMP_W-1:0] idx_ext, len_ext, max_ext;
  logic             idx_ok, inwin_d;

  assign idx_step = ANG_W'({{(ANG_W-IDX_W){1'b0}}, sample_index_i} * ang_step_q);
  assign ang_d    = start_ang_q + idx_step;

  always_comb begin
    if (scan_len_q == SCAN_LEN_MID) begin
      right_edge = RIGHT_MID;
      left_edge  = LEFT_MID;
    end else if (scan_len_q == SCAN_LEN_LONG) begin
      right_edge = RIGHT_LONG;
      left_edge  = LEFT_LONG;
    end else begin
      right_edge = RIGHT_DEF;
      left_edge  = LEFT_DEF;
    end
  end

  assign idx_ext = CMP_W'(sample_index_i);
  assign len_ext = CMP_W'(scan_len_q);
  assign max_ext = CMP_W'(MAX_SAMPLES);
  assign idx_ok  = (idx_ext < len_ext) && (idx_ext < max_ext);
  assign inwin_d = idx_ok && ((sample_index_i <= right_edge) || (sample_index_i >= left_edge));

  // stage 1: octant fold and angle to radians
  logic [ANG_W-1:0]      shifted;
  logic [MAG_W-1:0]      mag;
  logic [MAG_W+PI_W-1:0] thp_d, thp_q;

  assign shifted = ang_q + EIGHTH_TURN;
  assign mag     = shifted[13] ? {1'b0, shifted[12:0]} : (MAG_EIGHTH - {1'b0, shifted[12:0]});
  assign thp_d   = {{PI_W{1'b0}}, mag} * {{MAG_W{1'b0}}, PI_Q30};

  // stage 2: square of the angle
  logic [TH_W-1:0]   th;
  logic [2*TH_W-1:0] x2p_d, x2p_q;
  logic [X2_W-1:0]   x2_now;

  assign th     = thp_q[Q_FRAC+TH_W-16:15];
  assign x2p_d  = {{TH_W{1'b0}}, th} * {{TH_W{1'b0}}, th};
  assign x2_now = x2p_q[Q_FRAC+X2_W-1:Q_FRAC];

  // sideband line
  always_comb begin
    sb_d[0].range = range_mm_i;
    sb_d[0].idx   = sample_index_i;
    sb_d[0].inwin = inwin_d;
    sb_d[0].quad  = QUAD_0;
    sb_d[0].neg   = 1'b0;
    sb_d[0].th    = '0;
    sb_d[0].x2    = '0;
    for (int k = 1; k <= SB_LAST; k++) begin
      sb_d[k] = sb_q[k-1];
    end
    sb_d[1].quad  = quad_e'(shifted[15:14]);
    sb_d[1].neg   = ~shifted[13];
    sb_d[2].th    = th;
    sb_d[ST_X2].x2 = x2_now;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k <= SB_LAST; k++) begin
        sb_q[k] <= sb_d[k];
      end
      ang_q <= ang_d;
      thp_q <= thp_d;
      x2p_q <= x2p_d;
    end
  end

  // series evaluation
  logic [S_W-1:0] cos_s [N_COS];
  logic [S_W-1:0] sin_s [N_SIN];

  for (genvar j = 0; j < N_COS; j++) begin : g_cos
    logic [X2_W-1:0] x2_in;
    logic [S_W-1:0]  s_in;
    if (j == 0) begin : g_first
      assign x2_in = x2_now;
      assign s_in  = Q30_ONE;
    end else begin : g_next
      assign x2_in = sb_q[2+STEP_LAT*j].x2;
      assign s_in  = cos_s[j-1];
    end
    swp_horner_step #(.DIV(COS_DIV[j])) u_step (
      .clk_i (clk_i),
      .en_i  (en),
      .x2_i  (x2_in),
      .s_i   (s_in),
      .s_o   (cos_s[j])
    );
  end

  for (genvar j = 0; j < N_SIN; j++) begin : g_sin
    logic [X2_W-1:0] x2_in;
    logic [S_W-1:0]  s_in;
    if (j == 0) begin : g_first
      assign x2_in = x2_now;
      assign s_in  = Q30_ONE;
    end else begin : g_next
      assign x2_in = sb_q[2+STEP_LAT*j].x2;
      assign s_in  = sin_s[j-1];
    end
    swp_horner_step #(.DIV(SIN_DIV[j])) u_step (
      .clk_i (clk_i),
      .en_i  (en),
      .x2_i  (x2_in),
      .s_i   (s_in),
      .s_o   (sin_s[j])
    );
  end

  // sine times angle, then two delay stages to meet the cosine
  logic [TH_W+S_W-1:0] sp_d, sp_q;
  logic [S_W-1:0]      sd1_q, sd2_q;

  assign sp_d = {{S_W{1'b0}}, sb_q[ST_SIN].th} * {{TH_W{1'b0}}, sin_s[N_SIN-1]};

  // range products
  logic [RANGE_W+S_W-1:0] xp_d, yp_d, xp_q, yp_q;

  assign xp_d = {{S_W{1'b0}}, sb_q[ST_COS].range} * {{RANGE_W{1'b0}}, cos_s[N_COS-1]};
  assign yp_d = {{S_W{1'b0}}, sb_q[ST_COS].range} * {{RANGE_W{1'b0}}, sd2_q};

  always_ff @(posedge clk_i) begin
    if (en) begin
      sp_q  <= sp_d;
      sd1_q <= sp_q[Q_FRAC+S_W-1:Q_FRAC];
      sd2_q <= sd1_q;
      xp_q  <= xp_d;
      yp_q  <= yp_d;
    end
  end

  // rounding and quadrant rotation
  logic [47:0]            xr, yr;
  logic signed [XY_W-1:0] xc, ys, x_d, y_d;
  logic signed [XY_W-1:0] x_q, y_q;
  logic                   inwin_q;
  logic [IDX_W-1:0]       idx_q;

  assign xr = 48'(xp_q) + ROUND_HALF;
  assign yr = 48'(yp_q) + ROUND_HALF;
  assign xc = XY_W'(xr >> Q_FRAC);
  assign ys = sb_q[ST_MUL].neg ? -XY_W'(yr >> Q_FRAC) : XY_W'(yr >> Q_FRAC);

  always_comb begin
    case (sb_q[ST_MUL].quad)
      QUAD_0: begin
        x_d = xc;
        y_d = ys;
      end
      QUAD_1: begin
        x_d = -ys;
        y_d = xc;
      end
      QUAD_2: begin
        x_d = -xc;
        y_d = -ys;
      end
      QUAD_3: begin
        x_d = ys;
        y_d = -xc;
      end
      default: begin
        x_d = xc;
        y_d = ys;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_q     <= x_d;
      y_q     <= y_d;
      inwin_q <= sb_q[ST_MUL].inwin;
      idx_q   <= sb_q[ST_MUL].idx;
    end
  end

  assign out_valid_o  = vld_q[NSTG-1];
  assign x_mm_o       = x_q;
  assign y_mm_o       = y_q;
  assign in_window_o  = inwin_q;
  assign index_echo_o = idx_q;

  // checks
  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline valid bits moved during a stall");

  a_win_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && in_window_o |-> ({1'b0, index_echo_o} < scan_len_q))
    else $error("window flag set for index beyond scan length");

  a_win_default: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && in_window_o && (scan_len_q != SCAN_LEN_MID) && (scan_len_q != SCAN_LEN_LONG)
    |-> (index_echo_o <= RIGHT_DEF) || (index_echo_o >= LEFT_DEF))
    else $error("window flag outside default edges");

  a_xy_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (x_mm_o != {1'b1, {(XY_W-1){1'b0}}}) && (y_mm_o != {1'b1, {(XY_W-1){1'b0}}}))
    else $error("coordinate word at most negative code");

endmodule

// ----- test/tb_scan_window_polar_to_xy.sv -----
// testbench for scan_window_polar_to_xy: random and directed lidar samples checked against an xy predictor
`timescale 1ns / 100ps

module tb_scan_window_polar_to_xy;
  import swp_pkg::*;

  localparam int          MAX_SAMPLES   = 2048;
  localparam int          SETTLE_CYCLES = 30;
  localparam int          STUCK_LIMIT   = 1000;
  localparam int          REPORT_LIMIT  = 10;
  localparam logic [CIDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam longint      Q30      = 64'sd1 << 30;
  localparam longint      Q30_HALF = 64'sd1 << 29;
  localparam longint      PI_FIX   = 64'sd3373259426;

  typedef struct packed {
    logic [RANGE_W-1:0] range_mm;
    logic [IDX_W-1:0]   index;
  } polar_sample_t;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic                   inwin;
    logic [IDX_W-1:0]       index;
  } xy_point_t;

  logic                   clk_i          = 1'b0;
  logic                   rst_ni         = 1'b0;
  logic                   in_valid_i     = 1'b0;
  logic                   in_ready_o;
  logic [RANGE_W-1:0]     range_mm_i     = '0;
  logic [IDX_W-1:0]       sample_index_i = '0;
  logic                   out_valid_o;
  logic                   out_ready_i    = 1'b0;
  logic signed [XY_W-1:0] x_mm_o;
  logic signed [XY_W-1:0] y_mm_o;
  logic                   in_window_o;
  logic [IDX_W-1:0]       index_echo_o;
  logic                   cfg_valid_i    = 1'b0;
  logic                   cfg_ready_o;
  logic [CIDX_W-1:0]      cfg_index_i    = '0;
  logic [CDATA_W-1:0]     cfg_data_i     = '0;

  logic [LEN_W-1:0] scan_len_q  = 12'd360;
  logic [ANG_W-1:0] start_ang_q = 16'h8000;
  logic [ANG_W-1:0] ang_step_q  = 16'd182;

  polar_sample_t scan_samples[$];
  xy_point_t     expected_points[$];
  polar_sample_t next_sample;
  xy_point_t     want;
  logic          sample_taken = 1'b0;
  bit            idle_mode    = 1'b1;
  int            send_gap     = 0;
  int            hold_gap     = 0;
  int            mismatches   = 0;
  int            stuck_cycles = 0;

  scan_window_polar_to_xy #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .range_mm_i    (range_mm_i),
    .sample_index_i(sample_index_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .x_mm_o        (x_mm_o),
    .y_mm_o        (y_mm_o),
    .in_window_o   (in_window_o),
    .index_echo_o  (index_echo_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic void window_edges(input logic [LEN_W-1:0] len, output int right_edge,
                                       output int left_edge);
    if (len == 12'd720) begin
      right_edge = 180;
      left_edge  = 540;
    end else if (len == 12'd1080) begin
      right_edge = 270;
      left_edge  = 810;
    end else begin
      right_edge = 90;
      left_edge  = 270;
    end
  endfunction

  function automatic xy_point_t project_sample(input logic [RANGE_W-1:0] range_mm,
                                               input logic [IDX_W-1:0] index);
    logic [ANG_W-1:0] ang;
    logic [ANG_W:0]   turned;
    int               resid;
    int               right_edge;
    int               left_edge;
    longint           th, x2, s, c, xc, ys, xv, yv;
    xy_point_t        pt;
    ang    = start_ang_q + index * ang_step_q;
    turned = {1'b0, ang} + 17'd8192;
    resid  = int'(turned[13:0]) - 8192;
    th = (longint'(resid < 0 ? -resid : resid) * PI_FIX) >>> 15;
    x2 = (th * th) >>> 30;
    // sine series to x^9
    s = Q30;
    s = Q30 - ((x2 * s) >>> 30) / 72;
    s = Q30 - ((x2 * s) >>> 30) / 42;
    s = Q30 - ((x2 * s) >>> 30) / 20;
    s = Q30 - ((x2 * s) >>> 30) / 6;
    s = (th * s) >>> 30;
    // cosine series to x^10
    c = Q30;
    c = Q30 - ((x2 * c) >>> 30) / 90;
    c = Q30 - ((x2 * c) >>> 30) / 56;
    c = Q30 - ((x2 * c) >>> 30) / 30;
    c = Q30 - ((x2 * c) >>> 30) / 12;
    c = Q30 - ((x2 * c) >>> 30) / 2;
    xc = (longint'(range_mm) * c + Q30_HALF) >>> 30;
    ys = (longint'(range_mm) * s + Q30_HALF) >>> 30;
    if (resid < 0) ys = -ys;
    case (quad_e'(turned[15:14]))
      QUAD_0: begin
        xv = xc;
        yv = ys;
      end
      QUAD_1: begin
        xv = -ys;
        yv = xc;
      end
      QUAD_2: begin
        xv = -xc;
        yv = -ys;
      end
      QUAD_3: begin
        xv = ys;
        yv = -xc;
      end
      default: begin
        xv = xc;
        yv = ys;
      end
    endcase
    window_edges(scan_len_q, right_edge, left_edge);
    pt.x     = xv[XY_W-1:0];
    pt.y     = yv[XY_W-1:0];
    pt.inwin = (index < scan_len_q) && (index < MAX_SAMPLES) &&
               (index <= right_edge || index >= left_edge);
    pt.index = index;
    return pt;
  endfunction

  // sender
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || sample_taken)) begin
      if (send_gap != 0) begin
        send_gap = send_gap - 1;
        in_valid_i <= 1'b0;
      end else if (idle_mode && $urandom_range(0, 5) == 0) begin
        send_gap = $urandom_range(0, 6);
        in_valid_i <= 1'b0;
      end else if (scan_samples.size() != 0) begin
        next_sample = scan_samples.pop_front();
        in_valid_i     <= 1'b1;
        range_mm_i     <= next_sample.range_mm;
        sample_index_i <= next_sample.index;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver stalls
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_gap != 0) begin
        hold_gap = hold_gap - 1;
        out_ready_i <= 1'b0;
      end else if (idle_mode && $urandom_range(0, 5) == 0) begin
        hold_gap = $urandom_range(0, 6);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // monitor and checker
  always @(posedge clk_i) begin
    sample_taken <= in_valid_i && in_ready_o;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o)
        expected_points.insert(expected_points.size(),
                               project_sample(range_mm_i, sample_index_i));
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_SCAN_LENGTH: scan_len_q  <= cfg_data_i[LEN_W-1:0];
          CFG_START_ANGLE: start_ang_q <= cfg_data_i;
          CFG_ANGLE_STEP:  ang_step_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_points.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("unexpected word: x %0d y %0d win %0b idx %0d",
                     x_mm_o, y_mm_o, in_window_o, index_echo_o);
        end else begin
          want = expected_points.pop_front();
          if (x_mm_o !== want.x || y_mm_o !== want.y || in_window_o !== want.inwin ||
              index_echo_o !== want.index) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display("mismatch: exp x %0d y %0d win %0b idx %0d, got x %0d y %0d win %0b idx %0d",
                       want.x, want.y, want.inwin, want.index,
                       x_mm_o, y_mm_o, in_window_o, index_echo_o);
          end
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o))
        stuck_cycles <= 0;
      else if (stuck_cycles == STUCK_LIMIT) begin
        $display("FAIL scan_window_polar_to_xy");
        $finish;
      end else
        stuck_cycles <= stuck_cycles + 1;
    end
  end

  task automatic push_sample(input logic [RANGE_W-1:0] range_mm, input logic [IDX_W-1:0] index);
    polar_sample_t smp;
    smp.range_mm = range_mm;
    smp.index    = index;
    scan_samples.insert(scan_samples.size(), smp);
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] reg_idx, input logic [CDATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= reg_idx;
    cfg_data_i  <= data;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    do @(posedge clk_i);
    while (scan_samples.size() != 0 || in_valid_i || expected_points.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_geometry(input logic [LEN_W-1:0] len, input logic [ANG_W-1:0] start_ang,
                              input logic [ANG_W-1:0] step);
    drain();
    // upper bits of the length word are don't care
    write_reg(CFG_SCAN_LENGTH, {4'($urandom), len});
    write_reg(CFG_START_ANGLE, start_ang);
    write_reg(CFG_ANGLE_STEP, step);
  endtask

  function automatic logic [RANGE_W-1:0] pick_range();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return RANGE_W'($urandom_range(0, 15));
      default: return RANGE_W'($urandom);
    endcase
  endfunction

  function automatic logic [IDX_W-1:0] pick_index();
    int right_edge;
    int left_edge;
    window_edges(scan_len_q, right_edge, left_edge);
    case ($urandom_range(0, 5))
      1:       return (scan_len_q == 0) ? '0 : IDX_W'($urandom_range(0, scan_len_q - 1));
      2:       return IDX_W'(right_edge + $urandom_range(0, 2) - 1);
      3:       return IDX_W'(left_edge + $urandom_range(0, 2) - 1);
      4:       return IDX_W'(scan_len_q - $urandom_range(0, 1));
      default: return IDX_W'($urandom);
    endcase
  endfunction

  task automatic run_random(input int count);
    int pushed;
    int base;
    int span;
    pushed = 0;
    while (pushed < count) begin
      if ($urandom_range(0, 3) == 0) begin
        // a run of consecutive indices as in a real scan
        base = $urandom_range(0, MAX_SAMPLES - 1);
        span = $urandom_range(4, 12);
        for (int k = 0; k < span; k++)
          push_sample(pick_range(), IDX_W'(base + k));
        pushed += span;
      end else begin
        push_sample(pick_range(), pick_index());
        pushed++;
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset geometry: extremes and window edges
    push_sample(16'd0, 11'd0);
    push_sample(16'hFFFF, 11'd0);
    push_sample(16'hFFFF, 11'd2047);
    push_sample(16'd1, 11'd90);
    push_sample(16'hFFFF, 11'd91);
    push_sample(16'd40000, 11'd270);
    push_sample(16'd12345, 11'd359);
    push_sample(16'd12345, 11'd360);

    // eighth-turn steps land on every octant boundary
    set_geometry(12'd720, 16'h0000, 16'd8192);
    write_reg(CFG_UNUSED, 16'($urandom));
    for (int k = 0; k < 8; k++)
      push_sample(16'hFFFF, IDX_W'(k));
    push_sample(16'd54321, 11'd180);
    push_sample(16'd54321, 11'd181);
    push_sample(16'd777, 11'd720);

    set_geometry(12'd1080, 16'hFFFF, 16'h0001);
    push_sample(16'hFFFF, 11'd0);
    push_sample(16'd30000, 11'd270);
    push_sample(16'd30000, 11'd271);
    push_sample(16'd30000, 11'd809);
    push_sample(16'd30000, 11'd810);
    push_sample(16'd30000, 11'd1080);

    set_geometry(12'd0, 16'h7FFF, 16'h8000);
    run_random(70);
    set_geometry(12'd4095, 16'h8000, 16'h7FFF);
    run_random(70);
    set_geometry(12'd1080, 16'($urandom), 16'($urandom));
    idle_mode = 1'b0;
    run_random(70);
    set_geometry(12'd2048, 16'($urandom), 16'h0001);
    idle_mode = 1'b1;
    run_random(70);
    set_geometry(12'd1, 16'($urandom), 16'hFFFF);
    run_random(60);
    set_geometry(12'd720, 16'($urandom), 16'($urandom));
    run_random(70);
    set_geometry(12'd360, 16'($urandom), 16'($urandom));
    run_random(70);
    set_geometry(12'($urandom), 16'($urandom), 16'($urandom));
    idle_mode = 1'b0;
    run_random(70);

    drain();
    if (mismatches == 0)
      $display("PASS scan_window_polar_to_xy");
    else
      $display("FAIL scan_window_polar_to_xy");
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/swp_pkg.sv
hw/rtl/swp_horner_step.sv
hw/rtl/scan_window_polar_to_xy.sv
test/tb_scan_window_polar_to_xy.sv
